[rtl/fsr_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the shape rasterizer.
`timescale 1ns / 1ps

package fsr_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 160;
    localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
    localparam int X_W    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int Y_W    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

    // Field widths
    localparam int REQ_W   = 3;
    localparam int POS_W   = 10;
    localparam int EXT_W   = 9;
    localparam int RAD_W   = 8;
    localparam int COLOR_W = 16;

    // Internal arithmetic widths
    localparam int COORD_W = 12;            // box corners before clipping
    localparam int SD_W    = RAD_W + 2;     // offset from a circle centre
    localparam int RR_W    = 2 * RAD_W;     // radius squared
    localparam int SQ_W    = RR_W + 1;      // running squared offsets

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RECT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CIRCLE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    // Box the datapath walks for one pass
    typedef enum logic [2:0] {
        BOX_FULL,
        BOX_PIXEL,
        BOX_RECT,
        BOX_TOP,
        BOX_BOTTOM,
        BOX_LEFT,
        BOX_RIGHT,
        BOX_CIRCLE
    } t_box;

    typedef struct packed {
        logic capture;     // latch the request payload
        logic zero_color;  // latch colour as zero (power-up clear)
        logic load;        // compute and clip the box
        t_box box;
        logic prep_a;      // square the column offset
        logic prep_b;      // square the row offset, set start address
        logic walk;        // visit one pixel
        logic rd;          // read the framebuffer
    } t_dp_cmd;

    typedef struct packed {
        logic empty;       // clipped box holds no pixel
        logic last;        // current pixel is the last of the box
    } t_dp_stat;

endpackage

[rtl/framebuffer_shape_rasterizer_core.sv]
// Top level of the framebuffer shape rasterizer: controller plus datapath.
`timescale 1ns / 1ps

// Draws into a 128 x 160 framebuffer of 16-bit pixels held in one single-port RAM,
// writing at most one pixel per clock. An item is taken when start is high and busy
// is low; each item gives exactly one result, shown for a single cycle with o_valid
// high, and the receiver cannot stall it, so capture it in that cycle. After reset the
// block sweeps the whole framebuffer to zero, holding busy high until the sweep ends;
// the sweep gives no result.
// A clear walks the whole screen; a set pixel writes one pixel and a read reads one; a
// filled rectangle or circle walks each pixel of the shape's bounding box after clipping
// to the screen; an outline rectangle walks its four sides in turn; a box that holds no
// pixel after clipping is skipped; an unused request code goes straight to its result.
// The shapes are drawn pixel by pixel through the single RAM write port. A new item
// may be taken in the very cycle the previous result is shown.

module framebuffer_shape_rasterizer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [fsr_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [fsr_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [fsr_pkg::POS_W-1:0]   i_pos_y,
    input  logic [fsr_pkg::EXT_W-1:0]          i_extent_w,
    input  logic [fsr_pkg::EXT_W-1:0]          i_extent_h,
    input  logic [fsr_pkg::RAD_W-1:0]          i_radius,
    input  logic [fsr_pkg::COLOR_W-1:0]        i_color,
    input  logic                               i_filled,
    output logic                               o_valid,
    output logic [fsr_pkg::COLOR_W-1:0]        o_read_data,
    output logic                               o_in_bounds
);

    fsr_pkg::t_dp_cmd            cmd;
    fsr_pkg::t_dp_stat           stat;
    logic [fsr_pkg::COLOR_W-1:0] rdata;

    // Controller: owns the handshake, sequences each box pass and the result strobe
    fsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_filled   (i_filled),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_hit      (o_in_bounds)
    );

    // Datapath: hold the item, clip each box, walk its pixels and store them
    fsr_datapath u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_extent_w (i_extent_w),
        .i_extent_h (i_extent_h),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .o_stat     (stat),
        .o_rdata    (rdata)
    );

    // Drop stale RAM data: only an on-screen read shows the pixel, all else reads zero
    assign o_read_data = o_in_bounds ? rdata : '0;

endmodule

[rtl/fsr_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module fsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                         i_wdata,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fsr_datapath.sv]
// Rasterizer datapath: box clipping, pixel walker, circle test and framebuffer.
`timescale 1ns / 1ps

module fsr_datapath (
    input  logic                              i_clk,
    input  fsr_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [fsr_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [fsr_pkg::POS_W-1:0]  i_pos_y,
    input  logic [fsr_pkg::EXT_W-1:0]         i_extent_w,
    input  logic [fsr_pkg::EXT_W-1:0]         i_extent_h,
    input  logic [fsr_pkg::RAD_W-1:0]         i_radius,
    input  logic [fsr_pkg::COLOR_W-1:0]       i_color,
    output fsr_pkg::t_dp_stat                 o_stat,
    output logic [fsr_pkg::COLOR_W-1:0]       o_rdata
);

    localparam int CW = fsr_pkg::COORD_W;

    // Latched request
    logic signed [fsr_pkg::POS_W-1:0] r_x, r_y;
    logic [fsr_pkg::EXT_W-1:0]        r_w, r_h;
    logic [fsr_pkg::RAD_W-1:0]        r_r;
    logic [fsr_pkg::COLOR_W-1:0]      r_color;

    // Clipped box and walker
    logic                             r_empty, r_circ;
    logic [fsr_pkg::X_W-1:0]          r_i0, r_i1, r_i;
    logic [fsr_pkg::Y_W-1:0]          r_j0, r_j1, r_j;
    logic [fsr_pkg::ADDR_W-1:0]       r_row_addr, r_addr;
    logic signed [fsr_pkg::SD_W-1:0]  r_dx0, r_dx, r_dy;
    logic [fsr_pkg::SQ_W-1:0]         r_dx0sq, r_dxsq, r_dysq;
    logic [fsr_pkg::RR_W-1:0]         r_rr;

    logic signed [CW-1:0] cx, cy, cw, ch, cr;
    logic signed [CW-1:0] xlo, xhi, ylo, yhi;
    logic signed [CW-1:0] xlo_c, xhi_c, ylo_c, yhi_c;
    logic signed [CW-1:0] dx0_n, dy0_n;
    logic                 empty_n;

    logic signed [2*fsr_pkg::SD_W-1:0] sq_dx, sq_dy;
    logic [fsr_pkg::ADDR_W-1:0]        row_base;
    logic [fsr_pkg::SQ_W:0]            sq_sum;
    logic signed [fsr_pkg::SQ_W+1:0]   dxsq_nx, dysq_nx;
    logic                              row_end, pix_we;

    assign cx = CW'(r_x);
    assign cy = CW'(r_y);
    assign cw = {{(CW - fsr_pkg::EXT_W){1'b0}}, r_w};
    assign ch = {{(CW - fsr_pkg::EXT_W){1'b0}}, r_h};
    assign cr = {{(CW - fsr_pkg::RAD_W){1'b0}}, r_r};

    always_comb begin
        unique case (i_cmd.box)
            fsr_pkg::BOX_FULL: begin
                xlo = '0;
                xhi = CW'(fsr_pkg::SCREEN_WIDTH - 1);
                ylo = '0;
                yhi = CW'(fsr_pkg::SCREEN_HEIGHT - 1);
            end
            fsr_pkg::BOX_PIXEL: begin
                xlo = cx;
                xhi = cx;
                ylo = cy;
                yhi = cy;
            end
            fsr_pkg::BOX_RECT: begin
                xlo = cx;
                xhi = cx + cw - CW'(1);
                ylo = cy;
                yhi = cy + ch - CW'(1);
            end
            fsr_pkg::BOX_TOP: begin
                xlo = cx;
                xhi = cx + cw - CW'(1);
                ylo = cy;
                yhi = cy;
            end
            fsr_pkg::BOX_BOTTOM: begin
                xlo = cx;
                xhi = cx + cw - CW'(1);
                ylo = cy + ch;
                yhi = cy + ch;
            end
            fsr_pkg::BOX_LEFT: begin
                xlo = cx;
                xhi = cx;
                ylo = cy;
                yhi = cy + ch - CW'(1);
            end
            fsr_pkg::BOX_RIGHT: begin
                xlo = cx + cw;
                xhi = cx + cw;
                ylo = cy;
                yhi = cy + ch - CW'(1);
            end
            fsr_pkg::BOX_CIRCLE: begin
                xlo = cx - cr;
                xhi = cx + cr - CW'(1);
                ylo = cy - cr;
                yhi = cy + cr - CW'(1);
            end
        endcase
    end

    // Clip to the screen
    always_comb begin
        xlo_c   = (xlo < 0) ? '0 : xlo;
        ylo_c   = (ylo < 0) ? '0 : ylo;
        xhi_c   = (xhi > CW'(fsr_pkg::SCREEN_WIDTH - 1))  ? CW'(fsr_pkg::SCREEN_WIDTH - 1)  : xhi;
        yhi_c   = (yhi > CW'(fsr_pkg::SCREEN_HEIGHT - 1)) ? CW'(fsr_pkg::SCREEN_HEIGHT - 1) : yhi;
        empty_n = (xlo_c > xhi_c) || (ylo_c > yhi_c);
        dx0_n   = cx - xlo_c;
        dy0_n   = cy - ylo_c;
    end

    assign sq_dx    = r_dx0 * r_dx0;
    assign sq_dy    = r_dy * r_dy;
    assign row_base = fsr_pkg::ADDR_W'(r_j0) * fsr_pkg::ADDR_W'(fsr_pkg::SCREEN_WIDTH)
                    + fsr_pkg::ADDR_W'(r_i0);

    // (d-1)^2 = d^2 - 2d + 1
    assign dxsq_nx = $signed({2'b00, r_dxsq}) - ((fsr_pkg::SQ_W + 2)'(r_dx) <<< 1)
                   + (fsr_pkg::SQ_W + 2)'(1);
    assign dysq_nx = $signed({2'b00, r_dysq}) - ((fsr_pkg::SQ_W + 2)'(r_dy) <<< 1)
                   + (fsr_pkg::SQ_W + 2)'(1);

    assign sq_sum  = (fsr_pkg::SQ_W + 1)'(r_dxsq) + (fsr_pkg::SQ_W + 1)'(r_dysq);
    assign row_end = (r_i == r_i1);
    assign pix_we  = i_cmd.walk && (!r_circ || (sq_sum <= (fsr_pkg::SQ_W + 1)'(r_rr)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_w     <= i_extent_w;
            r_h     <= i_extent_h;
            r_r     <= i_radius;
            r_color <= i_cmd.zero_color ? '0 : i_color;
        end
        if (i_cmd.load) begin
            r_empty <= empty_n;
            r_circ  <= (i_cmd.box == fsr_pkg::BOX_CIRCLE);
            r_i0    <= xlo_c[fsr_pkg::X_W-1:0];
            r_i1    <= xhi_c[fsr_pkg::X_W-1:0];
            r_j0    <= ylo_c[fsr_pkg::Y_W-1:0];
            r_j1    <= yhi_c[fsr_pkg::Y_W-1:0];
            r_dx0   <= dx0_n[fsr_pkg::SD_W-1:0];
            r_dy    <= dy0_n[fsr_pkg::SD_W-1:0];
            r_rr    <= r_r * r_r;
        end
        if (i_cmd.prep_a) begin
            r_dx0sq <= sq_dx[fsr_pkg::SQ_W-1:0];
        end
        if (i_cmd.prep_b) begin
            r_dysq     <= sq_dy[fsr_pkg::SQ_W-1:0];
            r_row_addr <= row_base;
            r_addr     <= row_base;
            r_i        <= r_i0;
            r_j        <= r_j0;
            r_dx       <= r_dx0;
            r_dxsq     <= r_dx0sq;
        end
        if (i_cmd.walk) begin
            if (row_end) begin
                r_i        <= r_i0;
                r_j        <= r_j + fsr_pkg::Y_W'(1);
                r_row_addr <= r_row_addr + fsr_pkg::ADDR_W'(fsr_pkg::SCREEN_WIDTH);
                r_addr     <= r_row_addr + fsr_pkg::ADDR_W'(fsr_pkg::SCREEN_WIDTH);
                r_dx       <= r_dx0;
                r_dxsq     <= r_dx0sq;
                r_dy       <= r_dy - fsr_pkg::SD_W'(1);
                r_dysq     <= dysq_nx[fsr_pkg::SQ_W-1:0];
            end else begin
                r_i    <= r_i + fsr_pkg::X_W'(1);
                r_addr <= r_addr + fsr_pkg::ADDR_W'(1);
                r_dx   <= r_dx - fsr_pkg::SD_W'(1);
                r_dxsq <= dxsq_nx[fsr_pkg::SQ_W-1:0];
            end
        end
    end

    assign o_stat.empty = r_empty;
    assign o_stat.last  = row_end && (r_j == r_j1);

    fsr_ram #(
        .WIDTH (fsr_pkg::COLOR_W),
        .DEPTH (fsr_pkg::PIX_COUNT)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_re    (i_cmd.rd),
        .i_addr  (r_addr),
        .i_wdata (r_color),
        .o_rdata (o_rdata)
    );

endmodule

[rtl/fsr_ctrl.sv]
// Rasterizer controller: sequences box passes, reads and the result strobe.
`timescale 1ns / 1ps

module fsr_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fsr_pkg::REQ_W-1:0]    i_req_type,
    input  logic                         i_filled,
    input  fsr_pkg::t_dp_stat            i_stat,
    output fsr_pkg::t_dp_cmd             o_cmd,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic                         o_hit
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOAD,
        S_PREP_A,
        S_PREP_B,
        S_WALK,
        S_READ,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    fsr_pkg::t_box r_box, n_box;
    logic          r_rd, n_rd;
    logic          r_silent, n_silent;
    logic          r_valid, r_hit, n_hit;
    logic          accept, box_done, more_box;
    fsr_pkg::t_box next_box;

    assign o_busy = !(r_state == S_IDLE || r_state == S_DONE);
    assign accept = i_start && !o_busy;

    // Outline rectangles take four passes: top, bottom, left, right
    always_comb begin
        more_box = 1'b1;
        next_box = r_box;
        unique case (r_box)
            fsr_pkg::BOX_TOP:    next_box = fsr_pkg::BOX_BOTTOM;
            fsr_pkg::BOX_BOTTOM: next_box = fsr_pkg::BOX_LEFT;
            fsr_pkg::BOX_LEFT:   next_box = fsr_pkg::BOX_RIGHT;
            default:             more_box = 1'b0;
        endcase
    end

    assign box_done = ((r_state == S_PREP_A) && i_stat.empty)
                   || ((r_state == S_WALK) && i_stat.last);

    always_comb begin
        n_state  = r_state;
        n_box    = r_box;
        n_rd     = r_rd;
        n_silent = r_silent;
        n_hit    = 1'b0;
        unique case (r_state)
            S_INIT: begin
                n_box    = fsr_pkg::BOX_FULL;
                n_rd     = 1'b0;
                n_silent = 1'b1;
                n_state  = S_LOAD;
            end
            S_IDLE, S_DONE: begin
                n_state = S_IDLE;
                if (accept) begin
                    n_silent = 1'b0;
                    n_rd     = (i_req_type == fsr_pkg::REQ_READ);
                    n_state  = S_LOAD;
                    unique case (i_req_type)
                        fsr_pkg::REQ_CLEAR:  n_box = fsr_pkg::BOX_FULL;
                        fsr_pkg::REQ_SET:    n_box = fsr_pkg::BOX_PIXEL;
                        fsr_pkg::REQ_RECT:   n_box = i_filled ? fsr_pkg::BOX_RECT
                                                              : fsr_pkg::BOX_TOP;
                        fsr_pkg::REQ_CIRCLE: n_box = fsr_pkg::BOX_CIRCLE;
                        fsr_pkg::REQ_READ:   n_box = fsr_pkg::BOX_PIXEL;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD:   n_state = S_PREP_A;
            S_PREP_A: n_state = S_PREP_B;
            S_PREP_B: n_state = r_rd ? S_READ : S_WALK;
            S_WALK:   n_state = S_WALK;
            S_READ: begin
                n_state = S_DONE;
                n_hit   = 1'b1;
            end
        endcase
        if (box_done) begin
            if (more_box) begin
                n_box   = next_box;
                n_state = S_LOAD;
            end else begin
                n_state = r_silent ? S_IDLE : S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_box    <= fsr_pkg::BOX_FULL;
            r_rd     <= 1'b0;
            r_silent <= 1'b1;
            r_valid  <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_box    <= n_box;
            r_rd     <= n_rd;
            r_silent <= n_silent;
            r_valid  <= (n_state == S_DONE);
            r_hit    <= n_hit;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = accept || (r_state == S_INIT);
        o_cmd.zero_color = (r_state == S_INIT);
        o_cmd.load       = (r_state == S_LOAD);
        o_cmd.box        = r_box;
        o_cmd.prep_a     = (r_state == S_PREP_A) && !i_stat.empty;
        o_cmd.prep_b     = (r_state == S_PREP_B);
        o_cmd.walk       = (r_state == S_WALK);
        o_cmd.rd         = (r_state == S_READ);
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

`ifndef SYNTHESIS
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("block not busy after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == fsr_pkg::REQ_CLEAR || i_req_type == fsr_pkg::REQ_SET
            || i_req_type == fsr_pkg::REQ_RECT || i_req_type == fsr_pkg::REQ_CIRCLE
            || i_req_type == fsr_pkg::REQ_READ)) |=> o_busy)
        else $error("drawing item accepted without going busy");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (o_valid && o_hit))
        else $error("framebuffer read not followed by an in-bounds result");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_valid)
        else $error("in-bounds flag raised outside a result");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.prep_a, o_cmd.prep_b, o_cmd.walk, o_cmd.rd}))
        else $error("datapath given more than one step at once");
`endif

endmodule
